// ----- sv/lus_pkg.sv -----
// Shared types, codes and fixed-point helpers of the LU linear system solver.
package lus_pkg;

  localparam int MaxSizeDefault = 8;
  localparam int DivSteps = 48;
  localparam int DivCntW = $clog2(DivSteps);

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_SOLVE  = 2'd2
  } lus_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INITW,
    S_PRD,
    S_QRD,
    S_MUL,
    S_ACC,
    S_FIN,
    S_PIVW,
    S_DIV,
    S_NEXT,
    S_ORD,
    S_OWT,
    S_SING
  } lus_state_e;

  typedef enum logic [1:0] {
    PH_U,
    PH_L,
    PH_F,
    PH_B
  } lus_phase_e;

  typedef struct packed {
    logic [2:0]         index;
    logic signed [31:0] value;
    logic               singular;
    logic               saturated;
    logic               last;
  } lus_res_t;

  function automatic logic sat32_ovf(input logic signed [63:0] v);
    return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

endpackage

// ----- sv/lus_div.sv -----
// Iterative signed Q16.16 divider, one quotient bit per cycle, saturating.
module lus_div import lus_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o,
  output logic               clip_o
);

  logic                 busy_q, done_q, neg_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [47:0]          dvd_q;
  logic [32:0]          rem_q;
  logic [31:0]          dsr_q;
  logic [32:0]          rem_sh;
  logic                 qbit;
  logic [31:0]          num_mag, den_mag;

  always_comb begin
    num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
    den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
    rem_sh  = {rem_q[31:0], dvd_q[47]};
    qbit    = rem_sh >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, 16'h0000};
      rem_q <= '0;
      dsr_q <= den_mag;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sh - {1'b0, dsr_q} : rem_sh;
      dvd_q <= {dvd_q[46:0], qbit};
    end
  end

  always_comb begin
    clip_o = 1'b0;
    quo_o  = 32'(dvd_q);
    if (!neg_q) begin
      if (dvd_q > 48'h0000_7FFF_FFFF) begin
        clip_o = 1'b1;
        quo_o  = 32'sh7FFF_FFFF;
      end
    end else if (dvd_q > 48'h0000_8000_0000) begin
      clip_o = 1'b1;
      quo_o  = 32'sh8000_0000;
    end else begin
      quo_o = 32'(-dvd_q);
    end
  end

  assign done_o = done_q;

endmodule

// ----- sv/lus_core.sv -----
// Sequencer, matrix and vector memories and multiply-accumulate datapath.
module lus_core import lus_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDefault,
  localparam int CW = $clog2(MAX_SIZE + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CW-1:0]      n_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [1:0]         command_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output lus_res_t           res_o
);

  localparam int MatDepth = MAX_SIZE * MAX_SIZE;
  localparam int VecDepth = 2 * MAX_SIZE;
  localparam int AW = $clog2(MatDepth);
  localparam int VW = $clog2(VecDepth);

  function automatic logic [AW-1:0] maddr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] t;
    t = r * MAX_SIZE + c;
    return t[AW-1:0];
  endfunction

  function automatic logic [VW-1:0] waddr(input logic [CW-1:0] x);
    logic [31:0] t;
    t = MAX_SIZE + 32'(x);
    return t[VW-1:0];
  endfunction

  lus_state_e state_q, state_d;
  lus_phase_e phase_q, phase_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [63:0] acc_q, acc_d, prod_q;
  logic signed [31:0] p_q, sat_q, sat_d;
  logic clip_q, clip_d, pivz_q, pivz_d;

  logic signed [31:0] mat_mem [MatDepth];
  logic signed [31:0] vec_mem [VecDepth];
  logic signed [31:0] mat_rdata_q, vec_rdata_q;
  logic [AW-1:0] mat_raddr, mat_waddr;
  logic [VW-1:0] vec_raddr, vec_waddr;
  logic mat_we, vec_we;
  logic signed [31:0] mat_wdata, vec_wdata;

  logic div_start, div_done, div_clip;
  logic signed [31:0] div_quo;

  logic [AW-1:0] init_m, p_m, q_m, piv_m;
  logic [VW-1:0] init_v, q_v;
  logic use_mat, need_div;
  logic [CW-1:0] k_start, k_end, i_inc, j_inc, k_inc;
  logic signed [31:0] init_data;
  logic [31:0] idx_w;

  always_comb begin
    use_mat  = (phase_q == PH_U) || (phase_q == PH_L);
    need_div = (phase_q == PH_L) || (phase_q == PH_B);
    i_inc = i_q + CW'(1);
    j_inc = j_q + CW'(1);
    k_inc = k_q + CW'(1);
    piv_m = maddr(32'(i_q), 32'(i_q));
    init_v = (phase_q == PH_F) ? VW'(i_q) : waddr(i_q);
    q_v = waddr(k_q);
    unique case (phase_q)
      PH_U: begin
        init_m = maddr(32'(i_q), 32'(j_q));
        p_m    = maddr(32'(i_q), 32'(k_q));
        q_m    = maddr(32'(k_q), 32'(j_q));
      end
      PH_L: begin
        init_m = maddr(32'(j_q), 32'(i_q));
        p_m    = maddr(32'(j_q), 32'(k_q));
        q_m    = maddr(32'(k_q), 32'(i_q));
      end
      default: begin
        init_m = maddr(32'(i_q), 32'(i_q));
        p_m    = maddr(32'(i_q), 32'(k_q));
        q_m    = maddr(32'(k_q), 32'(i_q));
      end
    endcase
    k_start = (phase_q == PH_B) ? i_inc : '0;
    k_end   = (phase_q == PH_B) ? n_i : i_q;
    init_data = use_mat ? mat_rdata_q : vec_rdata_q;
    idx_w = 32'(i_q);
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    acc_d = acc_q;
    sat_d = sat_q;
    clip_d = clip_q;
    pivz_d = pivz_q;
    mat_raddr = piv_m;
    vec_raddr = waddr(i_q);
    mat_we = 1'b0;
    vec_we = 1'b0;
    mat_waddr = init_m;
    vec_waddr = waddr(i_q);
    mat_wdata = sat_q;
    vec_wdata = sat_q;
    div_start = 1'b0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o.index = idx_w[2:0];
    res_o.value = vec_rdata_q;
    res_o.singular = 1'b0;
    res_o.saturated = clip_q;
    res_o.last = (i_inc == n_i);

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        mat_waddr = maddr(32'(row_i), 32'(col_i));
        vec_waddr = VW'(row_i);
        mat_wdata = value_i;
        vec_wdata = value_i;
        if (req_valid_i) begin
          unique case (command_i)
            CMD_LOAD_A: mat_we = (32'(row_i) < MAX_SIZE) && (32'(col_i) < MAX_SIZE);
            CMD_LOAD_B: vec_we = 32'(row_i) < MAX_SIZE;
            CMD_SOLVE: begin
              phase_d = PH_U;
              i_d = '0;
              j_d = '0;
              clip_d = 1'b0;
              state_d = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        mat_raddr = init_m;
        vec_raddr = init_v;
        state_d = S_INITW;
      end
      S_INITW: begin
        acc_d = {{32{init_data[31]}}, init_data};
        k_d = k_start;
        state_d = (k_start == k_end) ? S_FIN : S_PRD;
      end
      S_PRD: begin
        mat_raddr = p_m;
        state_d = S_QRD;
      end
      S_QRD: begin
        mat_raddr = q_m;
        vec_raddr = q_v;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        acc_d = acc_q - qround(prod_q);
        k_d = k_inc;
        state_d = (k_inc == k_end) ? S_FIN : S_PRD;
      end
      S_FIN: begin
        sat_d = sat32(acc_q);
        clip_d = clip_q | sat32_ovf(acc_q);
        mat_raddr = piv_m;
        if (need_div) begin
          state_d = S_PIVW;
        end else begin
          mat_wdata = sat32(acc_q);
          vec_wdata = sat32(acc_q);
          mat_we = use_mat;
          vec_we = !use_mat;
          if ((phase_q == PH_U) && (j_q == i_q)) begin
            pivz_d = sat32(acc_q) == 32'sd0;
          end
          state_d = S_NEXT;
        end
      end
      S_PIVW: begin
        div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        mat_wdata = div_quo;
        vec_wdata = div_quo;
        if (div_done) begin
          mat_we = use_mat;
          vec_we = !use_mat;
          clip_d = clip_q | div_clip;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        state_d = S_INIT;
        unique case (phase_q)
          PH_U: begin
            if (j_inc < n_i) begin
              j_d = j_inc;
            end else if (pivz_q) begin
              state_d = S_SING;
            end else if (i_inc < n_i) begin
              phase_d = PH_L;
              j_d = i_inc;
            end else begin
              phase_d = PH_F;
              i_d = '0;
            end
          end
          PH_L: begin
            if (j_inc < n_i) begin
              j_d = j_inc;
            end else begin
              phase_d = PH_U;
              i_d = i_inc;
              j_d = i_inc;
            end
          end
          PH_F: begin
            if (i_inc < n_i) begin
              i_d = i_inc;
            end else begin
              phase_d = PH_B;
              i_d = n_i - CW'(1);
            end
          end
          PH_B: begin
            if (i_q == '0) begin
              state_d = S_ORD;
            end else begin
              i_d = i_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
      S_ORD: state_d = S_OWT;
      S_OWT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (i_inc == n_i) begin
            state_d = S_IDLE;
          end else begin
            i_d = i_inc;
            state_d = S_ORD;
          end
        end
      end
      S_SING: begin
        res_valid_o = 1'b1;
        res_o.index = '0;
        res_o.value = '0;
        res_o.singular = 1'b1;
        res_o.last = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_U;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      clip_q <= 1'b0;
      pivz_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      clip_q <= clip_d;
      pivz_q <= pivz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sat_q <= sat_d;
    if (state_q == S_QRD) begin
      p_q <= mat_rdata_q;
    end
    if (state_q == S_MUL) begin
      prod_q <= 64'(p_q) * (use_mat ? 64'(mat_rdata_q) : 64'(vec_rdata_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
    mat_rdata_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_waddr] <= vec_wdata;
    end
    vec_rdata_q <= vec_mem[vec_raddr];
  end

  lus_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sat_q),
    .den_i   (mat_rdata_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .clip_o  (div_clip)
  );

endmodule

// ----- sv/lu_linear_system_solver_top.sv -----
// Top level: size register, output register and the solver core.
// Load requests (matrix element or right-hand element) are accepted back to back
// while the solver is idle. A solve request holds the block until its results are
// out: each element of L, U, y and x starts from one read and then takes, per
// multiply-accumulate term, two reads (both from the matrix memory for L and U, the
// second from the vector memory for y and x), one registered 32x32 multiply and one
// accumulate; each element of L and x then goes through the bit-serial 48-step divider.
// The result register lets a finished result wait while new loads are accepted.
module lu_linear_system_solver_top import lus_pkg::*; #(
  parameter int MAX_SIZE = MaxSizeDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         index_o,
  output logic signed [31:0] solution_value_o,
  output logic               singular_o,
  output logic               saturated_o,
  output logic               last_o
);

  localparam int CW = $clog2(MAX_SIZE + 1);

  logic [3:0] size_q;
  logic [31:0] n_full;
  logic [CW-1:0] n;
  logic out_valid_q, res_valid, res_ready;
  lus_res_t res, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (size_q == 4'd0) begin
      n_full = 32'd1;
    end else if (32'(size_q) > MAX_SIZE) begin
      n_full = 32'(MAX_SIZE);
    end else begin
      n_full = 32'(size_q);
    end
    n = n_full[CW-1:0];
    res_ready = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  lus_core #(
    .MAX_SIZE (MAX_SIZE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .command_i   (command_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign out_valid_o      = out_valid_q;
  assign index_o          = out_q.index;
  assign solution_value_o = out_q.value;
  assign singular_o       = out_q.singular;
  assign saturated_o      = out_q.saturated;
  assign last_o           = out_q.last;

endmodule

// ----- sv/lus_chk.sv -----
// Port-level checker for the solver top level, with its bind.
module lus_chk import lus_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         command_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         index_o,
  input logic signed [31:0] solution_value_o,
  input logic               singular_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(solution_value_o))
    else $error("result dropped or changed while stalled");

  a_singular_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> last_o && (index_o == 3'd0) && (solution_value_o == 32'sd0))
    else $error("singular result malformed");

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_SOLVE) |=> !in_ready_o)
    else $error("request accepted during solve");

endmodule

bind lu_linear_system_solver_top lus_chk u_lus_chk (.*);
